// ----- src/lasr_pkg.sv -----
`default_nettype none

package lasr_pkg;

    // data bytes of a frame that may still carry payload
    localparam int FRAME_BYTES = 10;

    // protected identifiers
    localparam logic [7:0] PID_POSITION = 8'h80;
    localparam logic [7:0] PID_STATUS   = 8'h64;
    localparam logic [7:0] PID_SAFETY   = 8'hE7;
    localparam logic [7:0] PID_COMMAND  = 8'hCA;

    // fixed status answer
    localparam logic [7:0] STATUS_BYTE0 = 8'h9A;
    localparam logic [7:0] STATUS_BYTE1 = 8'h01;

    localparam logic [3:0] SAFETY_PAIRS = 4'd9;
    localparam logic [3:0] COUNT_MAX    = 4'hF;
    localparam logic [15:0] TICKS_MAX   = 16'hFFFF;
    localparam logic [15:0] STALL_TIMEOUT_RESET = 16'd16384;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_TICK = 2'd1,
        OP_MOVE = 2'd2,
        OP_STOP = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_TX_BYTE  = 2'd0,
        KIND_POSITION = 2'd1,
        KIND_ACCEPTED = 2'd2,
        KIND_BUSY     = 2'd3
    } kind_t;

    // motion flag bits
    localparam int MF_REQ   = 0;
    localparam int MF_MOVE  = 1;
    localparam int MF_BLOCK = 2;

    typedef struct packed {
        logic        frame_active;
        logic [3:0]  byte_count;
        logic [7:0]  position_low;
        logic [7:0]  position_high;
        logic [3:0]  safety_index;
        logic        command_armed;
        logic [7:0]  command_low;
        logic [7:0]  command_high;
        logic [7:0]  command_check;
        logic [15:0] height_now;
        logic [15:0] height_requested;
        logic [15:0] height_active_goal;
        logic [15:0] height_at_last_change;
        logic [2:0]  motion_flags;
        logic [15:0] stall_ticks;
    } state_t;

    // one byte of the safety table, sel picks the second byte of the pair
    function automatic logic [7:0] safety_byte(input logic [3:0] idx, input logic sel);
        logic [15:0] pair;
        case (idx)
            4'd0:    pair = 16'h3FD8;
            4'd1:    pair = 16'hDF38;
            4'd2:    pair = 16'hCF48;
            4'd3:    pair = 16'hD740;
            4'd4:    pair = 16'hC354;
            4'd5:    pair = 16'hDD3A;
            4'd6:    pair = 16'hCC4B;
            4'd7:    pair = 16'h55C2;
            4'd8:    pair = 16'h8097;
            default: pair = 16'h3FD8;
        endcase
        return sel ? pair[7:0] : pair[15:8];
    endfunction

    // add with end-around carry
    function automatic logic [7:0] carry_wrap_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? (s[7:0] + 8'd1) : s[7:0];
    endfunction

    // inverted carry-wrap sum of the command pid and both goal bytes
    function automatic logic [7:0] command_checksum(input logic [7:0] lo, input logic [7:0] hi);
        return ~carry_wrap_add(carry_wrap_add(PID_COMMAND, lo), hi);
    endfunction

endpackage

`default_nettype wire

// ----- src/lin_actuator_slave_responder_core.sv -----
// LIN slave responder for a desk lift motor.
// Input stream s_*: one transfer per event. s_tuser[1:0] is the opcode
// (character, timer tick, move request, stop request); s_tdata carries the
// received character, its framing error flag and the wanted height.
// Output stream m_*: one transfer per result. m_tuser[1:0] is the result kind
// (transmit byte, position report, request accepted, refused busy),
// m_tdata[15:0] the value, m_tlast marks the final result of an input item.
// An item causes zero to three results.
// Config channel cfg_*: writes the stall timeout, always ready; write it
// only while no item is in flight.
// An item is registered on acceptance, evaluated once the result buffer is
// free, and its results are registered in the result buffer, which offers the first.
// Throughput: one item per cycle for items without results, otherwise one
// item per its results delivered; the three-entry result buffer drains one
// result per cycle while m_tready is high, and a new item is evaluated as the last result leaves.
// When the receiver stalls, the result buffer holds, the input register
// fills and s_tready drops until the buffer empties.
// Reset clears all motor and frame state, empties both stages and sets the
// stall timeout to 16384.
`default_nettype none

module lin_actuator_slave_responder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // rx_byte[7:0], framing_error[8], wanted_height[24:9]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // result_value[15:0]
    output logic [1:0]       m_tuser,   // result_kind[1:0]
    output logic             m_tlast,   // last_of_run
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // stall_timeout
);

    // input register
    logic                      in_valid_reg;
    lasr_pkg::opcode_t         in_op_reg;
    logic [7:0]                in_byte_reg;
    logic                      in_ferr_reg;
    logic [15:0]               in_wanted_reg;

    // block state
    lasr_pkg::state_t          state_reg, state_next;
    logic [15:0]               stall_timeout_reg;

    // result buffer, entry 0 is the head
    lasr_pkg::kind_t           buf_kind_reg [3];
    logic [15:0]               buf_value_reg [3];
    logic [1:0]                buf_count_reg;

    // evaluation results
    lasr_pkg::kind_t           res_kind [3];
    logic [15:0]               res_value [3];
    logic [1:0]                res_count;

    logic                      proc_fire;
    logic                      pop;

    assign pop       = m_tvalid && m_tready;
    assign proc_fire = in_valid_reg &&
                       ((buf_count_reg == 2'd0) || ((buf_count_reg == 2'd1) && m_tready));
    assign s_tready  = !in_valid_reg || proc_fire;
    assign cfg_ready = 1'b1;

    assign m_tvalid = (buf_count_reg != 2'd0);
    assign m_tdata  = buf_value_reg[0];
    assign m_tuser  = buf_kind_reg[0];
    assign m_tlast  = (buf_count_reg == 2'd1);

    // input register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg     <= lasr_pkg::opcode_t'(s_tuser);
            in_byte_reg   <= s_tdata[7:0];
            in_ferr_reg   <= s_tdata[8];
            in_wanted_reg <= s_tdata[24:9];
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_timeout_reg <= lasr_pkg::STALL_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stall_timeout_reg <= cfg_data;
        end
    end

    // evaluation of one item against the state
    always_comb
    begin
        lasr_pkg::state_t s;
        logic [15:0]      pos;
        logic [15:0]      ref_height;
        logic [3:0]       idx;
        logic [1:0]       n;

        s   = state_reg;
        n   = 2'd0;
        pos = {state_reg.position_high, state_reg.position_low};
        idx = 4'd0;
        ref_height = 16'd0;
        for (int k = 0; k < 3; k++)
        begin
            res_kind[k]  = lasr_pkg::KIND_TX_BYTE;
            res_value[k] = 16'd0;
        end

        case (in_op_reg)
            lasr_pkg::OP_CHAR:
            begin
                if ((in_byte_reg == 8'd0) && in_ferr_reg)
                begin
                    // break closes the frame
                    if (s.frame_active)
                    begin
                        if (pos != s.height_now)
                        begin
                            if (s.height_now == 16'd0)
                            begin
                                res_kind[n]  = lasr_pkg::KIND_POSITION;
                                res_value[n] = pos;
                                n = n + 2'd1;
                            end
                            s.height_now = pos;
                        end
                        // stall check
                        if (s.motion_flags[lasr_pkg::MF_MOVE])
                        begin
                            if (s.height_at_last_change != s.height_now)
                            begin
                                s.height_at_last_change = s.height_now;
                                s.stall_ticks = 16'd0;
                            end
                            else if (s.stall_ticks >= stall_timeout_reg)
                            begin
                                s.motion_flags[lasr_pkg::MF_BLOCK] = 1'b1;
                            end
                        end
                        // start, arrival and stop
                        if (s.motion_flags[lasr_pkg::MF_REQ])
                        begin
                            if (!s.motion_flags[lasr_pkg::MF_MOVE])
                            begin
                                if (s.height_now != s.height_requested)
                                begin
                                    s.height_active_goal    = s.height_requested;
                                    s.command_low           = s.height_requested[7:0];
                                    s.command_high          = s.height_requested[15:8];
                                    s.command_check         = lasr_pkg::command_checksum(
                                        s.height_requested[7:0], s.height_requested[15:8]);
                                    s.command_armed         = 1'b1;
                                    s.stall_ticks           = 16'd0;
                                    s.height_at_last_change = s.height_now;
                                    s.motion_flags          = 3'b011;
                                end
                            end
                            else if (s.motion_flags[lasr_pkg::MF_BLOCK] ||
                                     (s.height_now == s.height_active_goal))
                            begin
                                s.command_armed = 1'b0;
                                s.motion_flags  = 3'b000;
                                res_kind[n]  = lasr_pkg::KIND_POSITION;
                                res_value[n] = s.height_now;
                                n = n + 2'd1;
                            end
                        end
                        else if (s.motion_flags[lasr_pkg::MF_MOVE])
                        begin
                            s.command_armed = 1'b0;
                            s.motion_flags  = 3'b000;
                            res_kind[n]  = lasr_pkg::KIND_POSITION;
                            res_value[n] = s.height_now;
                            n = n + 2'd1;
                        end
                    end
                    s.byte_count   = 4'd0;
                    s.frame_active = 1'b0;
                end
                else if (!in_ferr_reg)
                begin
                    if (s.byte_count == 4'd0)
                    begin
                        // protected identifier
                        s.frame_active = (in_byte_reg == lasr_pkg::PID_POSITION);
                        if (in_byte_reg == lasr_pkg::PID_STATUS)
                        begin
                            res_value[0] = {8'd0, lasr_pkg::STATUS_BYTE0};
                            res_value[1] = {8'd0, lasr_pkg::STATUS_BYTE1};
                            n = 2'd2;
                        end
                        else if ((in_byte_reg == lasr_pkg::PID_SAFETY) && s.command_armed)
                        begin
                            idx = (s.safety_index >= lasr_pkg::SAFETY_PAIRS) ? 4'd0
                                                                             : s.safety_index;
                            res_value[0] = {8'd0, lasr_pkg::safety_byte(idx, 1'b0)};
                            res_value[1] = {8'd0, lasr_pkg::safety_byte(idx, 1'b1)};
                            n = 2'd2;
                            s.safety_index = (idx + 4'd1 >= lasr_pkg::SAFETY_PAIRS) ? 4'd0
                                                                                     : idx + 4'd1;
                        end
                        else if ((in_byte_reg == lasr_pkg::PID_COMMAND) && s.command_armed)
                        begin
                            res_value[0] = {8'd0, s.command_low};
                            res_value[1] = {8'd0, s.command_high};
                            res_value[2] = {8'd0, s.command_check};
                            n = 2'd3;
                        end
                    end
                    else if (({1'b0, s.byte_count} < 5'(lasr_pkg::FRAME_BYTES)) &&
                             s.frame_active)
                    begin
                        if (s.byte_count == 4'd1)
                        begin
                            s.position_low = in_byte_reg;
                        end
                        else if (s.byte_count == 4'd2)
                        begin
                            s.position_high = in_byte_reg;
                        end
                    end
                    if (s.byte_count < lasr_pkg::COUNT_MAX)
                    begin
                        s.byte_count = s.byte_count + 4'd1;
                    end
                end
            end
            lasr_pkg::OP_TICK:
            begin
                if (s.stall_ticks < lasr_pkg::TICKS_MAX)
                begin
                    s.stall_ticks = s.stall_ticks + 16'd1;
                end
            end
            lasr_pkg::OP_MOVE:
            begin
                ref_height = s.motion_flags[lasr_pkg::MF_MOVE] ? s.height_active_goal
                                                               : s.height_now;
                if ((in_wanted_reg != ref_height) && s.motion_flags[lasr_pkg::MF_MOVE])
                begin
                    res_kind[0] = lasr_pkg::KIND_BUSY;
                end
                else
                begin
                    if (in_wanted_reg != ref_height)
                    begin
                        s.height_requested = in_wanted_reg;
                        s.motion_flags[lasr_pkg::MF_REQ] = 1'b1;
                    end
                    res_kind[0] = lasr_pkg::KIND_ACCEPTED;
                end
                n = 2'd1;
            end
            lasr_pkg::OP_STOP:
            begin
                s.motion_flags[lasr_pkg::MF_REQ] = 1'b0;
                res_kind[0] = lasr_pkg::KIND_ACCEPTED;
                n = 2'd1;
            end
            default:
            begin
                s = state_reg;
            end
        endcase

        state_next = s;
        res_count  = n;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (proc_fire)
        begin
            state_reg <= state_next;
        end
    end

    // result buffer count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_count_reg <= 2'd0;
        end
        else if (proc_fire)
        begin
            buf_count_reg <= res_count;
        end
        else if (pop)
        begin
            buf_count_reg <= buf_count_reg - 2'd1;
        end
    end

    // result buffer payload: load on evaluation, shift on each output transfer
    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            for (int k = 0; k < 3; k++)
            begin
                buf_kind_reg[k]  <= res_kind[k];
                buf_value_reg[k] <= res_value[k];
            end
        end
        else if (pop)
        begin
            buf_kind_reg[0]  <= buf_kind_reg[1];
            buf_value_reg[0] <= buf_value_reg[1];
            buf_kind_reg[1]  <= buf_kind_reg[2];
            buf_value_reg[1] <= buf_value_reg[2];
        end
    end

endmodule

`default_nettype wire

// ----- tb/lasr_response_checker.sv -----
`timescale 1ns / 100ps

module lasr_response_checker
    import lasr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // rx_byte[7:0], framing_error[8], wanted_height[24:9]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // result_value[15:0]
    input  wire logic [1:0]  m_tuser,   // result_kind[1:0]
    input  wire logic        m_tlast,   // last_of_run
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,  // stall_timeout
    output int               mismatch_count,
    output int               results_owed
);

    typedef struct packed {
        kind_t       kind;
        logic [15:0] value;
        logic        last;
    } response_t;

    // safety pairs, pair 0 in the lowest word, first byte in the upper half
    localparam logic [9*16-1:0] SAFETY_WORDS = {
        16'h8097, 16'h55C2, 16'hCC4B, 16'hDD3A, 16'hC354,
        16'hD740, 16'hCF48, 16'hDF38, 16'h3FD8
    };

    response_t   owed_results[$];
    response_t   staged[3];

    // predicted responder state
    logic [15:0] stall_limit;
    logic        in_frame;
    logic [3:0]  char_count;
    logic [7:0]  pos_lo;
    logic [7:0]  pos_hi;
    logic [3:0]  safety_ptr;
    logic        cmd_armed;
    logic [7:0]  cmd_lo;
    logic [7:0]  cmd_hi;
    logic [7:0]  cmd_sum;
    logic [15:0] cur_height;
    logic [15:0] req_height;
    logic [15:0] goal_height;
    logic [15:0] still_height;
    logic [2:0]  motion;
    logic [15:0] tick_count;

    // inverted end-around-carry sum of the command pid and the goal bytes
    function automatic logic [7:0] command_sum_check(input logic [7:0] lo, input logic [7:0] hi);
        logic [8:0] acc;
        acc = {1'b0, PID_COMMAND} + {1'b0, lo};
        if (acc[8])
            acc = {1'b0, acc[7:0]} + 9'd1;
        acc = {1'b0, acc[7:0]} + {1'b0, hi};
        if (acc[8])
            acc = {1'b0, acc[7:0]} + 9'd1;
        return ~acc[7:0];
    endfunction

    // hold one result of the item being predicted, three at most
    function automatic int stage_result(input int n, input kind_t k, input logic [15:0] v);
        if (n >= 3)
            return n;
        staged[n].kind  = k;
        staged[n].value = v;
        staged[n].last  = 1'b0;
        return n + 1;
    endfunction

    task automatic predict_responses(input opcode_t op, input logic [7:0] rx, input logic ferr,
                                     input logic [15:0] wanted);
        int          n;
        int          i;
        logic [15:0] frame_height;
        logic [15:0] ref_height;
        logic [3:0]  idx;
        response_t   r;
        n = 0;
        case (op)
            OP_CHAR:
            begin
                if (rx == 8'h00 && ferr)
                begin
                    // break closes the frame, a position frame runs the motion logic
                    if (in_frame)
                    begin
                        frame_height = {pos_hi, pos_lo};
                        if (frame_height != cur_height)
                        begin
                            if (cur_height == 16'd0)
                                n = stage_result(n, KIND_POSITION, frame_height);
                            cur_height = frame_height;
                        end
                        // stall detection on an unchanged height
                        if (motion[MF_MOVE])
                        begin
                            if (still_height != cur_height)
                            begin
                                still_height = cur_height;
                                tick_count   = 16'd0;
                            end
                            else if (tick_count >= stall_limit)
                                motion[MF_BLOCK] = 1'b1;
                        end
                        if (motion[MF_REQ])
                        begin
                            if (!motion[MF_MOVE])
                            begin
                                // start a move and arm the command
                                if (cur_height != req_height)
                                begin
                                    goal_height  = req_height;
                                    cmd_lo       = goal_height[7:0];
                                    cmd_hi       = goal_height[15:8];
                                    cmd_sum      = command_sum_check(cmd_lo, cmd_hi);
                                    cmd_armed    = 1'b1;
                                    tick_count   = 16'd0;
                                    still_height = cur_height;
                                    motion       = (3'b001 << MF_REQ) | (3'b001 << MF_MOVE);
                                end
                            end
                            else if (motion[MF_BLOCK] || cur_height == goal_height)
                            begin
                                cmd_armed = 1'b0;
                                motion    = 3'b000;
                                n = stage_result(n, KIND_POSITION, cur_height);
                            end
                        end
                        else if (motion[MF_MOVE])
                        begin
                            // request withdrawn while moving
                            cmd_armed = 1'b0;
                            motion    = 3'b000;
                            n = stage_result(n, KIND_POSITION, cur_height);
                        end
                    end
                    char_count = 4'd0;
                    in_frame   = 1'b0;
                end
                else if (!ferr)
                begin
                    if (char_count == 4'd0)
                    begin
                        // protected identifier
                        in_frame = (rx == PID_POSITION);
                        if (rx == PID_STATUS)
                        begin
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, STATUS_BYTE0});
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, STATUS_BYTE1});
                        end
                        else if (rx == PID_SAFETY && cmd_armed)
                        begin
                            idx = (safety_ptr >= SAFETY_PAIRS) ? 4'd0 : safety_ptr;
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, SAFETY_WORDS[idx*16+8 +: 8]});
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, SAFETY_WORDS[idx*16 +: 8]});
                            safety_ptr = (idx + 4'd1 >= SAFETY_PAIRS) ? 4'd0 : idx + 4'd1;
                        end
                        else if (rx == PID_COMMAND && cmd_armed)
                        begin
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, cmd_lo});
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, cmd_hi});
                            n = stage_result(n, KIND_TX_BYTE, {8'd0, cmd_sum});
                        end
                    end
                    else if (char_count < FRAME_BYTES && in_frame)
                    begin
                        if (char_count == 4'd1)
                            pos_lo = rx;
                        else if (char_count == 4'd2)
                            pos_hi = rx;
                    end
                    if (char_count != COUNT_MAX)
                        char_count = char_count + 4'd1;
                end
            end
            OP_TICK:
            begin
                if (tick_count != TICKS_MAX)
                    tick_count = tick_count + 16'd1;
            end
            OP_MOVE:
            begin
                ref_height = motion[MF_MOVE] ? goal_height : cur_height;
                if (wanted != ref_height && motion[MF_MOVE])
                    n = stage_result(n, KIND_BUSY, 16'd0);
                else
                begin
                    if (wanted != ref_height)
                    begin
                        req_height     = wanted;
                        motion[MF_REQ] = 1'b1;
                    end
                    n = stage_result(n, KIND_ACCEPTED, 16'd0);
                end
            end
            OP_STOP:
            begin
                motion[MF_REQ] = 1'b0;
                n = stage_result(n, KIND_ACCEPTED, 16'd0);
            end
        endcase
        // queue the results, last one marked
        for (i = 0; i < n; i++)
        begin
            r      = staged[i];
            r.last = (i == n - 1);
            owed_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // watch all three channels, results before the new item of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            owed_results.delete();
            mismatch_count = 0;
            results_owed  <= 0;
            stall_limit    = STALL_TIMEOUT_RESET;
            in_frame       = 1'b0;
            char_count     = 4'd0;
            pos_lo         = 8'd0;
            pos_hi         = 8'd0;
            safety_ptr     = 4'd0;
            cmd_armed      = 1'b0;
            cmd_lo         = 8'd0;
            cmd_hi         = 8'd0;
            cmd_sum        = 8'd0;
            cur_height     = 16'd0;
            req_height     = 16'd0;
            goal_height    = 16'd0;
            still_height   = 16'd0;
            motion         = 3'b000;
            tick_count     = 16'd0;
        end
        else
        begin
            // result transfer
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("unexpected result: kind %0d value %h last %b",
                           m_tuser, m_tdata, m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("result_kind", {14'd0, want.kind}, {14'd0, m_tuser});
                    check_field("result_value", want.value, m_tdata);
                    check_field("last_of_run", {15'd0, want.last}, {15'd0, m_tlast});
                end
            end
            // register write
            if (cfg_valid && cfg_ready)
                stall_limit = cfg_data;
            // input transfer
            if (s_tvalid && s_tready)
                predict_responses(opcode_t'(s_tuser), s_tdata[7:0], s_tdata[8], s_tdata[24:9]);
            results_owed <= owed_results.size();
        end
    end

endmodule

// ----- tb/lin_actuator_slave_responder_core_test.sv -----
`timescale 1ns / 100ps

module lin_actuator_slave_responder_core_test;

    import lasr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = 32'd0;
    logic [1:0]  s_tuser   = OP_CHAR;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'd0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic [1:0]  m_tuser;
    wire logic        m_tlast;
    wire logic        cfg_ready;
    int          mismatch_count;
    int          results_owed;

    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    int          cycle_count        = 0;
    int          items_sent         = 0;
    logic [15:0] last_goal          = 16'd0;
    logic [15:0] seen_height        = 16'd0;

    lin_actuator_slave_responder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lasr_response_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one input transfer, with a random gap ahead of it
    task automatic send_item(input opcode_t op, input logic [7:0] rx, input logic ferr,
                             input logic [15:0] wanted);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, wanted, ferr, rx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic put_char(input logic [7:0] b);
        send_item(OP_CHAR, b, 1'b0, 16'($urandom));
    endtask

    task automatic put_break();
        send_item(OP_CHAR, 8'h00, 1'b1, 16'($urandom));
    endtask

    task automatic put_tick();
        send_item(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic put_move(input logic [15:0] h);
        send_item(OP_MOVE, 8'($urandom), 1'($urandom), h);
    endtask

    task automatic put_stop();
        send_item(OP_STOP, 8'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // let the block run dry before touching the register
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // heights that tend to hit the goal, repeat the last one or start fresh
    function automatic logic [15:0] pick_height();
        case ($urandom_range(3))
            0:       return last_goal;
            1:       return seen_height;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(3));
        endcase
    endfunction

    // mostly well-formed frames and requests, some noise
    task automatic run_random(input int count);
        int          target;
        int          choice;
        int          extra;
        int          i;
        logic [15:0] h;
        target = items_sent + count;
        while (items_sent < target)
        begin
            choice = $urandom_range(99);
            if (choice < 30)
            begin
                // position frame, sometimes short, sometimes overlong
                h = pick_height();
                put_char(PID_POSITION);
                extra = $urandom_range(9);
                if (extra >= 1)
                    put_char(h[7:0]);
                if (extra >= 2)
                begin
                    put_char(h[15:8]);
                    seen_height = h;
                end
                if (extra >= 8)
                    for (i = 0; i < $urandom_range(14, 1); i++)
                        put_char(8'($urandom));
                put_break();
            end
            else if (choice < 45)
            begin
                for (i = 0; i < $urandom_range(6, 1); i++)
                    put_tick();
            end
            else if (choice < 60)
            begin
                h = pick_height();
                last_goal = h;
                put_move(h);
            end
            else if (choice < 65)
                put_stop();
            else if (choice < 80)
            begin
                // answer frames
                case ($urandom_range(2))
                    0:       put_char(PID_STATUS);
                    1:       put_char(PID_SAFETY);
                    default: put_char(PID_COMMAND);
                endcase
                for (i = 0; i < $urandom_range(2); i++)
                    put_char(8'($urandom));
                put_break();
            end
            else
            begin
                // noise: any field pattern, zero bytes favored
                send_item(opcode_t'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom),
                          1'($urandom), 16'($urandom));
            end
        end
    endtask

    initial
    begin
        int          phase;
        logic [15:0] timeout_value;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: status, unarmed answers, ignored error, move, answers, busy, stop
        put_char(PID_STATUS);
        put_break();
        put_char(PID_SAFETY);
        put_break();
        send_item(OP_CHAR, 8'h55, 1'b1, 16'hFFFF);
        put_move(16'hFFFF);
        put_char(PID_POSITION);
        put_char(8'h00);
        put_char(8'h01);
        put_break();
        put_char(PID_SAFETY);
        put_break();
        put_char(PID_COMMAND);
        put_break();
        put_move(16'h0000);
        put_move(16'hFFFF);
        put_stop();
        put_tick();
        put_char(PID_POSITION);
        put_char(8'hFF);
        put_char(8'hFF);
        put_break();
        put_char(8'h3C);
        put_char(8'h12);
        put_break();
        last_goal   = 16'hFFFF;
        seen_height = 16'hFFFF;

        // random phases over timeout and idling settings
        for (phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0:
                begin
                    timeout_value      = 16'd0;
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    timeout_value      = 16'hFFFF;
                    sender_idle_pct    = 54;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    timeout_value      = 16'($urandom_range(6, 1));
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 54;
                end
                default:
                begin
                    timeout_value      = 16'($urandom_range(40, 7));
                    sender_idle_pct    = 22;
                    receiver_stall_pct = 22;
                end
            endcase
            write_timeout(timeout_value);
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
